// ----- hw/rtl/closest_point_on_triangle_edges_unit_assert.svh -----
// Assertion macros shared by the RTL of the closest point unit.
// Every property is sampled on clk_i and is off while rst_ni is low.
`ifndef CLOSEST_POINT_ON_TRIANGLE_EDGES_UNIT_ASSERT_SVH
`define CLOSEST_POINT_ON_TRIANGLE_EDGES_UNIT_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define CPTE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CPTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cpte_pkg.sv -----
`default_nettype none

package cpte_pkg;

  // Coordinate and intermediate widths.
  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DEN_W   = PROD_W + 1;
  localparam int NUM_W   = PROD_W + 2;
  localparam int NLO_W   = (DEN_W + 1) / 2;
  localparam int NHI_W   = DEN_W - NLO_W;
  localparam int QUO_W   = DIFF_W;
  localparam int DVD_W   = DIFF_W + DEN_W;
  localparam int DIST_W  = PROD_W + 1;

  // Pipeline depth: seven front stages, one stage per quotient bit, three back stages.
  localparam int EDGE_STAGES = QUO_W + 10;
  localparam int NSTAGE      = EDGE_STAGES + 1;

  // Edge codes.
  localparam logic [1:0] EDGE_AB = 2'd0;
  localparam logic [1:0] EDGE_BC = 2'd1;
  localparam logic [1:0] EDGE_CA = 2'd2;

  // Three coordinates, x at index 0.
  typedef logic [2:0][COORD_W-1:0] vec3_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cpte_edge.sv -----
`default_nettype none

// Closest point on one segment to the query point, with its squared distance.
// All registers advance together on adv_i.
module cpte_edge (
  input  logic                         clk_i,
  input  logic                         adv_i,
  input  cpte_pkg::vec3_t              start_i,
  input  cpte_pkg::vec3_t              end_i,
  input  cpte_pkg::vec3_t              query_i,
  output cpte_pkg::vec3_t              point_o,
  output logic [cpte_pkg::DIST_W-1:0]  dist_o
);

  // Stage 0: captured operands.
  cpte_pkg::vec3_t s0_q, e0_q, p0_q;
  // Stage 1: edge and query offsets.
  logic signed [cpte_pkg::DIFF_W-1:0] v1_q [3];
  logic signed [cpte_pkg::DIFF_W-1:0] c1_q [3];
  cpte_pkg::vec3_t s1_q, e1_q, p1_q;
  // Stage 2: products.
  logic signed [cpte_pkg::PROD_W-1:0] vc2_q [3];
  logic signed [cpte_pkg::PROD_W-1:0] vv2_q [3];
  logic signed [cpte_pkg::DIFF_W-1:0] v2_q [3];
  cpte_pkg::vec3_t s2_q, e2_q, p2_q;
  // Stage 3: dot products.
  logic signed [cpte_pkg::NUM_W-1:0] num3_q;
  logic [cpte_pkg::DEN_W-1:0] den3_q;
  logic signed [cpte_pkg::DIFF_W-1:0] v3_q [3];
  cpte_pkg::vec3_t s3_q, e3_q, p3_q;
  // Stage 4: clamp decision.
  logic start_sel, at_end;
  logic [2:0] neg_d;
  logic [cpte_pkg::DIFF_W-1:0] mag_d [3];
  cpte_pkg::vec3_t base_d;
  logic mid4_q;
  cpte_pkg::vec3_t base4_q, p4_q;
  logic [2:0] neg4_q;
  logic [cpte_pkg::DIFF_W-1:0] mag4_q [3];
  logic [cpte_pkg::DEN_W-1:0] numm4_q, den4_q;
  // Stage 5: partial products of the dividend.
  logic [cpte_pkg::DIFF_W+cpte_pkg::NLO_W-1:0] pplo5_q [3];
  logic [cpte_pkg::DIFF_W+cpte_pkg::NHI_W-1:0] pphi5_q [3];
  logic mid5_q;
  cpte_pkg::vec3_t base5_q, p5_q;
  logic [2:0] neg5_q;
  logic [cpte_pkg::DEN_W-1:0] den5_q;
  // Stage 6 and the divider steps.
  logic [cpte_pkg::DVD_W-1:0] n6 [3];
  logic [cpte_pkg::DEN_W-1:0] dr_q   [cpte_pkg::QUO_W][3];
  logic [cpte_pkg::QUO_W-1:0] dl_q   [cpte_pkg::QUO_W][3];
  logic [cpte_pkg::DEN_W-1:0] dden_q [cpte_pkg::QUO_W];
  logic [cpte_pkg::QUO_W-1:0] dq_q   [cpte_pkg::QUO_W+1][3];
  logic                       dmid_q [cpte_pkg::QUO_W+1];
  cpte_pkg::vec3_t            dbase_q[cpte_pkg::QUO_W+1];
  cpte_pkg::vec3_t            dp_q   [cpte_pkg::QUO_W+1];
  logic [2:0]                 dneg_q [cpte_pkg::QUO_W+1];
  // Back stages.
  logic [cpte_pkg::COORD_W+1:0] sum_w [3];
  logic [cpte_pkg::COORD_W+1:0] step_w [3];
  cpte_pkg::vec3_t out_d;
  logic signed [cpte_pkg::DIFF_W-1:0] d_d [3];
  cpte_pkg::vec3_t out7_q, out8_q, out9_q;
  logic signed [cpte_pkg::DIFF_W-1:0] d7_q [3];
  logic signed [cpte_pkg::PROD_W-1:0] sq8_q [3];
  logic [cpte_pkg::DIST_W-1:0] dist9_q;

  // Capture the segment ends and the query point.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s0_q <= start_i;
      e0_q <= end_i;
      p0_q <= query_i;
    end
  end

  // Offsets of the end and the query point from the start.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        v1_q[i] <= $signed({e0_q[i][cpte_pkg::COORD_W-1], e0_q[i]})
                 - $signed({s0_q[i][cpte_pkg::COORD_W-1], s0_q[i]});
        c1_q[i] <= $signed({p0_q[i][cpte_pkg::COORD_W-1], p0_q[i]})
                 - $signed({s0_q[i][cpte_pkg::COORD_W-1], s0_q[i]});
      end
      s1_q <= s0_q;
      e1_q <= e0_q;
      p1_q <= p0_q;
    end
  end

  // Per-axis products for both dot products.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        vc2_q[i] <= v1_q[i] * c1_q[i];
        vv2_q[i] <= v1_q[i] * v1_q[i];
        v2_q[i]  <= v1_q[i];
      end
      s2_q <= s1_q;
      e2_q <= e1_q;
      p2_q <= p1_q;
    end
  end

  // Projection numerator and squared edge length.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      num3_q <= $signed({{2{vc2_q[0][cpte_pkg::PROD_W-1]}}, vc2_q[0]})
              + $signed({{2{vc2_q[1][cpte_pkg::PROD_W-1]}}, vc2_q[1]})
              + $signed({{2{vc2_q[2][cpte_pkg::PROD_W-1]}}, vc2_q[2]});
      den3_q <= {1'b0, vv2_q[0]} + {1'b0, vv2_q[1]} + {1'b0, vv2_q[2]};
      for (int i = 0; i < 3; i++) begin
        v3_q[i] <= v2_q[i];
      end
      s3_q <= s2_q;
      e3_q <= e2_q;
      p3_q <= p2_q;
    end
  end

  // Clamp: a degenerate edge or a projection at or before the start gives the start,
  // one at or past the end gives the end, anything else goes through the divider.
  always_comb begin
    start_sel = (den3_q == '0) || num3_q[cpte_pkg::NUM_W-1] || (num3_q == '0);
    at_end    = $unsigned(num3_q) >= {1'b0, den3_q};
    for (int i = 0; i < 3; i++) begin
      neg_d[i]  = v3_q[i][cpte_pkg::DIFF_W-1];
      mag_d[i]  = neg_d[i] ? (~v3_q[i] + 1'b1) : v3_q[i];
      base_d[i] = (!start_sel && at_end) ? e3_q[i] : s3_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mid4_q  <= !start_sel && !at_end;
      base4_q <= base_d;
      p4_q    <= p3_q;
      neg4_q  <= neg_d;
      for (int i = 0; i < 3; i++) begin
        mag4_q[i] <= mag_d[i];
      end
      numm4_q <= num3_q[cpte_pkg::DEN_W-1:0];
      den4_q  <= den3_q;
    end
  end

  // Dividend |v| * num in two partial products.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        pplo5_q[i] <= mag4_q[i] * numm4_q[cpte_pkg::NLO_W-1:0];
        pphi5_q[i] <= mag4_q[i] * numm4_q[cpte_pkg::DEN_W-1:cpte_pkg::NLO_W];
      end
      mid5_q  <= mid4_q;
      base5_q <= base4_q;
      p5_q    <= p4_q;
      neg5_q  <= neg4_q;
      den5_q  <= den4_q;
    end
  end

  // Sum the partial products and load the divider. The quotient is below |v|,
  // so the upper dividend bits already sit below the divisor.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n6[i] = cpte_pkg::DVD_W'(pplo5_q[i])
            + (cpte_pkg::DVD_W'(pphi5_q[i]) << cpte_pkg::NLO_W);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        dr_q[0][i] <= n6[i][cpte_pkg::DVD_W-1:cpte_pkg::QUO_W];
        dl_q[0][i] <= n6[i][cpte_pkg::QUO_W-1:0];
        dq_q[0][i] <= '0;
      end
      dden_q[0]  <= den5_q;
      dmid_q[0]  <= mid5_q;
      dbase_q[0] <= base5_q;
      dp_q[0]    <= p5_q;
      dneg_q[0]  <= neg5_q;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar j = 1; j <= cpte_pkg::QUO_W; j++) begin : g_div
    logic [cpte_pkg::DEN_W:0] trial [3];
    logic [cpte_pkg::DEN_W:0] rem   [3];
    logic [2:0]               qbit;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = {dr_q[j-1][i], dl_q[j-1][i][cpte_pkg::QUO_W-1]};
        qbit[i]  = trial[i] >= {1'b0, dden_q[j-1]};
        rem[i]   = qbit[i] ? (trial[i] - {1'b0, dden_q[j-1]}) : trial[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        for (int i = 0; i < 3; i++) begin
          dq_q[j][i] <= {dq_q[j-1][i][cpte_pkg::QUO_W-2:0], qbit[i]};
        end
        dmid_q[j]  <= dmid_q[j-1];
        dbase_q[j] <= dbase_q[j-1];
        dp_q[j]    <= dp_q[j-1];
        dneg_q[j]  <= dneg_q[j-1];
      end
    end

    if (j < cpte_pkg::QUO_W) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          for (int i = 0; i < 3; i++) begin
            dr_q[j][i] <= rem[i][cpte_pkg::DEN_W-1:0];
            dl_q[j][i] <= {dl_q[j-1][i][cpte_pkg::QUO_W-2:0], 1'b0};
          end
          dden_q[j] <= dden_q[j-1];
        end
      end
    end
  end

  // Candidate point, moved from the start toward the end by the quotient,
  // and its offset from the query point.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      step_w[i] = dneg_q[cpte_pkg::QUO_W][i]
                ? (~{1'b0, dq_q[cpte_pkg::QUO_W][i]} + 1'b1)
                : {1'b0, dq_q[cpte_pkg::QUO_W][i]};
      sum_w[i]  = {{2{dbase_q[cpte_pkg::QUO_W][i][cpte_pkg::COORD_W-1]}},
                   dbase_q[cpte_pkg::QUO_W][i]} + step_w[i];
      out_d[i]  = dmid_q[cpte_pkg::QUO_W] ? sum_w[i][cpte_pkg::COORD_W-1:0]
                                          : dbase_q[cpte_pkg::QUO_W][i];
      d_d[i]    = $signed({dp_q[cpte_pkg::QUO_W][i][cpte_pkg::COORD_W-1],
                           dp_q[cpte_pkg::QUO_W][i]})
                - $signed({out_d[i][cpte_pkg::COORD_W-1], out_d[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out7_q <= out_d;
      for (int i = 0; i < 3; i++) begin
        d7_q[i] <= d_d[i];
      end
    end
  end

  // Squared distance to the query point.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        sq8_q[i] <= d7_q[i] * d7_q[i];
      end
      out8_q <= out7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dist9_q <= {1'b0, sq8_q[0]} + {1'b0, sq8_q[1]} + {1'b0, sq8_q[2]};
      out9_q  <= out8_q;
    end
  end

  assign point_o = out9_q;
  assign dist_o  = dist9_q;

endmodule

`default_nettype wire

// ----- hw/rtl/closest_point_on_triangle_edges_unit.sv -----
`default_nettype none
// Channel  | Valid        | Stall        | Payload
// request  | in_valid_i   | in_stall_o   | vertex_{a,b,c}_{x,y,z}_i, query_{x,y,z}_i
// result   | out_valid_o  | out_stall_i  | closest_{x,y,z}_o, nearest_edge_o
//
// One request is accepted per cycle while in_stall_o is low; a result passes through
// the 44-stage pipeline (one divider stage per quotient bit) and then the output register.
// Reset clears the valid bits of the pipeline, the output register and the skid entry.
// A stalled result stays in the output register; the next result goes to the skid
// entry, and while that entry is full the whole pipeline and the request side hold.
`include "closest_point_on_triangle_edges_unit_assert.svh"

module closest_point_on_triangle_edges_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [cpte_pkg::COORD_W-1:0] vertex_a_x_i,
  input  logic signed [cpte_pkg::COORD_W-1:0] vertex_a_y_i,
  input  logic signed [cpte_pkg::COORD_W-1:0] vertex_a_z_i,
  input  logic signed [cpte_pkg::COORD_W-1:0] vertex_b_x_i,
  input  logic signed [cpte_pkg::COORD_W-1:0] vertex_b_y_i,
  input  logic signed [cpte_pkg::COORD_W-1:0] vertex_b_z_i,
  input  logic signed [cpte_pkg::COORD_W-1:0] vertex_c_x_i,
  input  logic signed [cpte_pkg::COORD_W-1:0] vertex_c_y_i,
  input  logic signed [cpte_pkg::COORD_W-1:0] vertex_c_z_i,
  input  logic signed [cpte_pkg::COORD_W-1:0] query_x_i,
  input  logic signed [cpte_pkg::COORD_W-1:0] query_y_i,
  input  logic signed [cpte_pkg::COORD_W-1:0] query_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [cpte_pkg::COORD_W-1:0] closest_x_o,
  output logic signed [cpte_pkg::COORD_W-1:0] closest_y_o,
  output logic signed [cpte_pkg::COORD_W-1:0] closest_z_o,
  output logic [1:0]                          nearest_edge_o
);

  cpte_pkg::vec3_t va, vb, vc, vp;
  cpte_pkg::vec3_t pt_ab, pt_bc, pt_ca;
  logic [cpte_pkg::DIST_W-1:0] d_ab, d_bc, d_ca;

  logic [cpte_pkg::NSTAGE-1:0] valid_q;
  logic adv;

  cpte_pkg::vec3_t best_pt_q, ca_pt_q;
  logic [cpte_pkg::DIST_W-1:0] best_d_q, ca_d_q;
  logic [1:0] best_e_q;

  cpte_pkg::vec3_t res_pt;
  logic [1:0] res_e;
  logic fin_valid, out_take;

  logic out_valid_q, skid_valid_q;
  cpte_pkg::vec3_t out_pt_q, skid_pt_q;
  logic [1:0] out_e_q, skid_e_q;

  // Pack the request coordinates, x at index 0.
  assign va = {vertex_a_z_i, vertex_a_y_i, vertex_a_x_i};
  assign vb = {vertex_b_z_i, vertex_b_y_i, vertex_b_x_i};
  assign vc = {vertex_c_z_i, vertex_c_y_i, vertex_c_x_i};
  assign vp = {query_z_i, query_y_i, query_x_i};

  // The pipeline advances as a whole unless the skid entry is full.
  assign adv        = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  cpte_edge u_edge_ab (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .start_i (va),
    .end_i   (vb),
    .query_i (vp),
    .point_o (pt_ab),
    .dist_o  (d_ab)
  );

  cpte_edge u_edge_bc (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .start_i (vb),
    .end_i   (vc),
    .query_i (vp),
    .point_o (pt_bc),
    .dist_o  (d_bc)
  );

  cpte_edge u_edge_ca (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .start_i (vc),
    .end_i   (va),
    .query_i (vp),
    .point_o (pt_ca),
    .dist_o  (d_ca)
  );

  // Valid bits travel alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[cpte_pkg::NSTAGE-2:0], in_valid_i};
    end
  end

  // First compare: bc wins over ab only when strictly nearer.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (d_bc < d_ab) begin
        best_pt_q <= pt_bc;
        best_d_q  <= d_bc;
        best_e_q  <= cpte_pkg::EDGE_BC;
      end else begin
        best_pt_q <= pt_ab;
        best_d_q  <= d_ab;
        best_e_q  <= cpte_pkg::EDGE_AB;
      end
      ca_pt_q <= pt_ca;
      ca_d_q  <= d_ca;
    end
  end

  // Second compare: ca wins only when strictly nearer.
  always_comb begin
    if (ca_d_q < best_d_q) begin
      res_pt = ca_pt_q;
      res_e  = cpte_pkg::EDGE_CA;
    end else begin
      res_pt = best_pt_q;
      res_e  = best_e_q;
    end
  end

  assign fin_valid = valid_q[cpte_pkg::NSTAGE-1] && adv;
  assign out_take  = out_valid_q && !out_stall_i;

  // Output register with one skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      priority if (skid_valid_q) begin
        if (out_take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (fin_valid) begin
        if (out_valid_q && !out_take) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (skid_valid_q) begin
      if (out_take) begin
        out_pt_q <= skid_pt_q;
        out_e_q  <= skid_e_q;
      end
    end else if (fin_valid) begin
      if (out_valid_q && !out_take) begin
        skid_pt_q <= res_pt;
        skid_e_q  <= res_e;
      end else begin
        out_pt_q <= res_pt;
        out_e_q  <= res_e;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign closest_x_o    = $signed(out_pt_q[0]);
  assign closest_y_o    = $signed(out_pt_q[1]);
  assign closest_z_o    = $signed(out_pt_q[2]);
  assign nearest_edge_o = out_e_q;

  // The skid entry is only ever filled behind a held result.
  `CPTE_ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q, "skid entry without result")
  // A full skid entry stays until the output register drains.
  `CPTE_ASSERT_NEXT(a_skid_holds, skid_valid_q && out_stall_i, skid_valid_q, "skid entry lost")
  // A frozen pipeline keeps its last item.
  `CPTE_ASSERT_NEXT(a_freeze_keeps, valid_q[cpte_pkg::NSTAGE-1] && !adv,
                    valid_q[cpte_pkg::NSTAGE-1], "pipeline item lost during stall")
  // A delivered edge code names a real edge.
  `CPTE_ASSERT_IMPL(a_edge_code, out_valid_o,
                    nearest_edge_o == cpte_pkg::EDGE_AB || nearest_edge_o == cpte_pkg::EDGE_BC ||
                    nearest_edge_o == cpte_pkg::EDGE_CA, "bad edge code")

endmodule

`default_nettype wire
